// File: rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers for the differential drive odometry.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

	localparam logic [1:0] REG_TPR    = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_AXLE   = 2'd2;

	localparam logic [31:0] PI_Q28        = 32'd843314857;
	localparam logic [31:0] TWO_PI_Q28    = 32'd1686629714;
	localparam logic [31:0] HALF_PI_Q28   = 32'd421657428;
	localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;
	localparam logic [50:0] RATE_K        = 51'd1686629714000000;
	localparam logic [31:0] RATE_K_LO     = RATE_K[31:0];
	localparam logic [18:0] RATE_K_HI     = RATE_K[50:32];
	localparam logic [29:0] PI_Q28_N      = PI_Q28[29:0];
	localparam logic [31:0] RECIP3        = 32'hAAAAAAAB;

	typedef struct packed {
		logic capture;
		logic delta;
		logic mul1;
		logic mul2;
		logic div_start;
		logic cor_h;
		logic fact;
		logic cor_a;
		logic mulm;
		logic mulxy;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cor_done;
		logic out_free;
	} sts_t;

	function automatic logic [27:0] atan_q28(input logic [4:0] i);
		logic [27:0] r;
		unique case (i)
			5'd0: r = 28'd210828714;
			5'd1: r = 28'd124459457;
			5'd2: r = 28'd65760959;
			5'd3: r = 28'd33381290;
			5'd4: r = 28'd16755422;
			5'd5: r = 28'd8385879;
			5'd6: r = 28'd4193963;
			5'd7: r = 28'd2097109;
			5'd8: r = 28'd1048571;
			5'd9: r = 28'd524287;
			5'd10: r = 28'd262144;
			5'd11: r = 28'd131072;
			5'd12: r = 28'd65536;
			5'd13: r = 28'd32768;
			5'd14: r = 28'd16384;
			5'd15: r = 28'd8192;
			5'd16: r = 28'd4096;
			5'd17: r = 28'd2048;
			5'd18: r = 28'd1024;
			5'd19: r = 28'd512;
			5'd20: r = 28'd256;
			5'd21: r = 28'd128;
			5'd22: r = 28'd64;
			5'd23: r = 28'd32;
			5'd24: r = 28'd16;
			5'd25: r = 28'd8;
			5'd26: r = 28'd4;
			5'd27: r = 28'd2;
			5'd28: r = 28'd1;
			default: r = 28'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] wrap_angle(input logic signed [33:0] a);
		logic signed [33:0] r;
		r = a;
		if (r >= $signed({2'b00, PI_Q28}))
			r = r - $signed({2'b00, TWO_PI_Q28});
		if (r < -$signed({2'b00, PI_Q28}))
			r = r + $signed({2'b00, TWO_PI_Q28});
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		logic signed [31:0] r;
		if (v > 41'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -41'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/core/ddo_in_if.sv
// ----------------------------------------------------------------------------
// ddo_in_if
// Input channel: encoder counts and timestamp of one sample.
// ----------------------------------------------------------------------------
interface ddo_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;
	logic        [31:0] time_us;

	modport source(output valid, output left_count, output right_count, output time_us,
		input ready);
	modport sink(input valid, input left_count, input right_count, input time_us,
		output ready);
endinterface

// File: rtl/core/ddo_out_if.sv
// ----------------------------------------------------------------------------
// ddo_out_if
// Output channel: pose and wheel rates.
// ----------------------------------------------------------------------------
interface ddo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [30:0] heading;
	logic signed [31:0] left_rate;
	logic signed [31:0] right_rate;

	modport source(output valid, output pos_x, output pos_y, output heading,
		output left_rate, output right_rate, input ready);
	modport sink(input valid, input pos_x, input pos_y, input heading,
		input left_rate, input right_rate, output ready);
endinterface

// File: rtl/core/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Bit-serial 128 by 64 divider, one quotient bit per cycle, with a
// saturating cap or a reducing modulus.
// ----------------------------------------------------------------------------
module ddo_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	input  logic [33:0]  cap,
	input  logic [31:0]  modulus,
	input  logic         use_mod,
	output logic [33:0]  quo,
	output logic         done
);

	logic [127:0] num_q;
	logic [63:0]  rem_q;
	logic [33:0]  quo_q;
	logic         over_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;

	logic [63:0] rem_sh;
	logic        ge;
	logic [33:0] q2;
	logic [33:0] q_mod;

	assign rem_sh = {rem_q[62:0], num_q[127]};
	assign ge     = rem_sh >= den;
	assign q2     = {quo_q[32:0], ge};
	assign q_mod  = (q2 >= {2'b00, modulus}) ? q2 - {2'b00, modulus} : q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			rem_q  <= '0;
			quo_q  <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= ge ? rem_sh - den : rem_sh;
			if (use_mod) begin
				quo_q <= q_mod;
			end else if (!over_q) begin
				if (q2 > cap)
					over_q <= 1'b1;
				else
					quo_q <= q2;
			end
		end
	end

	assign quo  = over_q ? cap : quo_q;
	assign done = done_q;

endmodule

// File: rtl/core/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode cordic, one iteration per cycle, Q4.30 cos and sin of a
// Q4.28 angle folded into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module ddo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic signed [33:0] cos_o,
	output logic signed [33:0] sin_o,
	output logic               done
);

	localparam logic [4:0] LAST = 5'(ddo_pkg::CORDIC_ITERS - 1);

	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [31:0] z_q;
	logic               neg_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               done_q;

	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [31:0] at;
	logic signed [31:0] pi_s;
	logic signed [31:0] half_s;

	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign at     = $signed({4'b0000, ddo_pkg::atan_q28(i_q)});
	assign pi_s   = $signed(ddo_pkg::PI_Q28);
	assign half_s = $signed(ddo_pkg::HALF_PI_Q28);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed(ddo_pkg::CORDIC_GAIN);
			y_q <= '0;
			if (angle > half_s) begin
				z_q   <= angle - pi_s;
				neg_q <= 1'b1;
			end else if (angle < -half_s) begin
				z_q   <= angle + pi_s;
				neg_q <= 1'b1;
			end else begin
				z_q   <= angle;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;
	assign done  = done_q;

endmodule

// File: rtl/core/ddo_dp.sv
// ----------------------------------------------------------------------------
// ddo_dp
// Odometry datapath: deltas, staged products, four dividers, shared cordic,
// pose accumulation and the result register.
// ----------------------------------------------------------------------------
module ddo_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ddo_pkg::cmd_t      cmd,
	output ddo_pkg::sts_t      sts,
	input  logic signed [31:0] in_left,
	input  logic signed [31:0] in_right,
	input  logic        [31:0] in_time,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [30:0] cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [30:0] out_heading,
	output logic signed [31:0] out_lrate,
	output logic signed [31:0] out_rrate
);

	logic [15:0] tpr_q;
	logic [30:0] rad_q;
	logic [30:0] axl_q;

	logic [31:0] last_l_q, last_r_q, last_t_q;
	logic signed [31:0] x_q, y_q, th_q;
	logic [31:0] in_l_q, in_r_q, in_t_q;

	logic [31:0] ml_q, mr_q;
	logic [32:0] msum_q, mdiff_q;
	logic        nl_q, nr_q, ns_q, nd_q;
	logic [31:0] dt_q;
	logic [15:0] tpr_e_q;
	logic [30:0] axl_e_q;

	logic [63:0] rl0_q, rr0_q;
	logic [50:0] rl1_q, rr1_q;
	logic [62:0] ps_q, pd_q;
	logic [47:0] rden_q;
	logic [46:0] hden_q;

	logic [82:0] numl_q, numr_q;
	logic [62:0] psl_q, pdl_q;
	logic [61:0] psh_q, pdh_q;

	logic signed [31:0] h_q;
	logic signed [31:0] wl_q, wr_q;
	logic signed [33:0] ds_q;
	logic [30:0]        f_q;
	logic signed [31:0] a_q;
	logic signed [35:0] m_q;
	logic signed [39:0] px_q, py_q;

	logic               ov_q;
	logic signed [31:0] o_x_q, o_y_q, o_l_q, o_r_q;
	logic signed [30:0] o_h_q;

	logic signed [31:0] dl_c, dr_c;
	logic signed [32:0] sum_c, diff_c;
	logic [93:0]        nums_c, numd_c;
	logic [33:0]        q_l, q_r, q_s, q_h;
	logic               dv_l, dv_r, dv_s, dv_h;
	logic [31:0]        hn_c;
	logic signed [31:0] h_c;
	logic signed [33:0] cor_c, cor_s;
	logic               cor_done;
	logic signed [31:0] cor_ang;
	logic signed [33:0] fsum_c;
	logic [63:0]        fprod_c;
	logic signed [65:0] mprod_c;
	logic signed [69:0] xprod_c, yprod_c;
	logic               out_free;

	assign dl_c   = $signed(in_l_q - last_l_q);
	assign dr_c   = $signed(in_r_q - last_r_q);
	assign sum_c  = {dl_c[31], dl_c} + {dr_c[31], dr_c};
	assign diff_c = {dr_c[31], dr_c} - {dl_c[31], dl_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_q    <= 16'd1024;
			rad_q    <= 31'd3277;
			axl_q    <= 31'd13107;
			last_l_q <= '0;
			last_r_q <= '0;
			last_t_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
			th_q     <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ddo_pkg::REG_TPR:    tpr_q <= cfg_wdata[15:0];
					ddo_pkg::REG_RADIUS: rad_q <= cfg_wdata;
					ddo_pkg::REG_AXLE:   axl_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.delta) begin
				last_l_q <= in_l_q;
				last_r_q <= in_r_q;
				last_t_q <= in_t_q;
			end
			if (cmd.commit) begin
				x_q  <= ddo_pkg::sat32(41'(x_q) + 41'(px_q));
				y_q  <= ddo_pkg::sat32(41'(y_q) + 41'(py_q));
				th_q <= ddo_pkg::wrap_angle(34'(a_q) + 34'(h_q));
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_l_q <= in_left;
			in_r_q <= in_right;
			in_t_q <= in_time;
		end
		if (cmd.delta) begin
			ml_q    <= dl_c[31] ? ~dl_c + 32'd1 : dl_c;
			mr_q    <= dr_c[31] ? ~dr_c + 32'd1 : dr_c;
			msum_q  <= sum_c[32] ? ~sum_c + 33'd1 : sum_c;
			mdiff_q <= diff_c[32] ? ~diff_c + 33'd1 : diff_c;
			nl_q    <= dl_c[31];
			nr_q    <= dr_c[31];
			ns_q    <= sum_c[32];
			nd_q    <= diff_c[32];
			dt_q    <= in_t_q - last_t_q;
			tpr_e_q <= (tpr_q == '0) ? 16'd1 : tpr_q;
			axl_e_q <= (axl_q == '0) ? 31'd1 : axl_q;
		end
		if (cmd.mul1) begin
			rl0_q  <= ml_q * ddo_pkg::RATE_K_LO;
			rr0_q  <= mr_q * ddo_pkg::RATE_K_LO;
			rl1_q  <= ml_q * ddo_pkg::RATE_K_HI;
			rr1_q  <= mr_q * ddo_pkg::RATE_K_HI;
			ps_q   <= msum_q * ddo_pkg::PI_Q28_N;
			pd_q   <= mdiff_q * ddo_pkg::PI_Q28_N;
			rden_q <= tpr_e_q * dt_q;
			hden_q <= tpr_e_q * axl_e_q;
		end
		if (cmd.mul2) begin
			numl_q <= {rl1_q, 32'd0} + 83'(rl0_q);
			numr_q <= {rr1_q, 32'd0} + 83'(rr0_q);
			psl_q  <= ps_q[31:0] * rad_q;
			psh_q  <= ps_q[62:32] * rad_q;
			pdl_q  <= pd_q[31:0] * rad_q;
			pdh_q  <= pd_q[62:32] * rad_q;
		end
		if (cmd.cor_h) begin
			h_q <= h_c;
			if (dt_q == '0)
				wl_q <= '0;
			else if (nl_q)
				wl_q <= $signed(~q_l[31:0] + 32'd1);
			else
				wl_q <= q_l[31] ? 32'sh7FFFFFFF : $signed(q_l[31:0]);
			if (dt_q == '0)
				wr_q <= '0;
			else if (nr_q)
				wr_q <= $signed(~q_r[31:0] + 32'd1);
			else
				wr_q <= q_r[31] ? 32'sh7FFFFFFF : $signed(q_r[31:0]);
			ds_q <= ns_q ? -$signed(q_s) : $signed(q_s);
		end
		if (cmd.fact) begin
			f_q <= fprod_c[63:33];
			a_q <= ddo_pkg::wrap_angle(34'(th_q) + 34'(h_q));
		end
		if (cmd.mulm)
			m_q <= mprod_c[65:30];
		if (cmd.mulxy) begin
			px_q <= xprod_c[69:30];
			py_q <= yprod_c[69:30];
		end
		if (cmd.commit) begin
			o_x_q <= ddo_pkg::sat32(41'(x_q) + 41'(px_q));
			o_y_q <= ddo_pkg::sat32(41'(y_q) + 41'(py_q));
			o_h_q <= 31'(ddo_pkg::wrap_angle(34'(a_q) + 34'(h_q)));
			o_l_q <= wl_q;
			o_r_q <= wr_q;
		end
	end

	assign nums_c = {psh_q, 32'd0} + 94'(psl_q);
	assign numd_c = {pdh_q, 32'd0} + 94'(pdl_q);

	ddo_div u_div_l (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(128'(numl_q)),
		.den(64'({rden_q, 12'd0})), .cap(34'h080000000), .modulus('0), .use_mod(1'b0),
		.quo(q_l), .done(dv_l)
	);

	ddo_div u_div_r (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(128'(numr_q)),
		.den(64'({rden_q, 12'd0})), .cap(34'h080000000), .modulus('0), .use_mod(1'b0),
		.quo(q_r), .done(dv_r)
	);

	ddo_div u_div_s (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(128'(nums_c)),
		.den(64'({tpr_e_q, 28'd0})), .cap(34'h100000000), .modulus('0), .use_mod(1'b0),
		.quo(q_s), .done(dv_s)
	);

	ddo_div u_div_h (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(128'(numd_c)),
		.den(64'(hden_q)), .cap('0), .modulus(ddo_pkg::TWO_PI_Q28), .use_mod(1'b1),
		.quo(q_h), .done(dv_h)
	);

	assign hn_c = (nd_q && q_h[31:0] != '0) ? ddo_pkg::TWO_PI_Q28 - q_h[31:0] : q_h[31:0];
	assign h_c  = (hn_c >= ddo_pkg::PI_Q28) ? $signed(hn_c - ddo_pkg::TWO_PI_Q28)
		: $signed(hn_c);

	assign cor_ang = cmd.cor_h ? h_c : a_q;

	ddo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.cor_h | cmd.cor_a), .angle(cor_ang),
		.cos_o(cor_c), .sin_o(cor_s), .done(cor_done)
	);

	assign fsum_c  = 34'sh080000000 + cor_c;
	assign fprod_c = fsum_c[31:0] * ddo_pkg::RECIP3;
	assign mprod_c = 66'(ds_q) * 66'($signed({1'b0, f_q}));
	assign xprod_c = 70'(m_q) * 70'(cor_c);
	assign yprod_c = 70'(m_q) * 70'(cor_s);

	assign out_free = !ov_q || out_ready;

	assign sts.div_done = dv_l & dv_r & dv_s & dv_h;
	assign sts.cor_done = cor_done;
	assign sts.out_free = out_free;

	assign out_valid   = ov_q;
	assign out_x       = o_x_q;
	assign out_y       = o_y_q;
	assign out_heading = o_h_q;
	assign out_lrate   = o_l_q;
	assign out_rrate   = o_r_q;

endmodule

// File: rtl/core/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer that steps one sample through the odometry datapath.
// ----------------------------------------------------------------------------
module ddo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output ddo_pkg::cmd_t cmd,
	input  ddo_pkg::sts_t sts
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DELTA  = 4'd1;
	localparam logic [3:0] ST_MUL1   = 4'd2;
	localparam logic [3:0] ST_MUL2   = 4'd3;
	localparam logic [3:0] ST_DIVGO  = 4'd4;
	localparam logic [3:0] ST_DIV    = 4'd5;
	localparam logic [3:0] ST_CORH   = 4'd6;
	localparam logic [3:0] ST_CORHW  = 4'd7;
	localparam logic [3:0] ST_FACT   = 4'd8;
	localparam logic [3:0] ST_CORA   = 4'd9;
	localparam logic [3:0] ST_CORAW  = 4'd10;
	localparam logic [3:0] ST_MULM   = 4'd11;
	localparam logic [3:0] ST_MULXY  = 4'd12;
	localparam logic [3:0] ST_COMMIT = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DELTA;
				end
			end
			ST_DELTA: begin
				cmd.delta = 1'b1;
				state_d   = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_DIVGO;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_CORH;
			end
			ST_CORH: begin
				cmd.cor_h = 1'b1;
				state_d   = ST_CORHW;
			end
			ST_CORHW: begin
				if (sts.cor_done)
					state_d = ST_FACT;
			end
			ST_FACT: begin
				cmd.fact = 1'b1;
				state_d  = ST_CORA;
			end
			ST_CORA: begin
				cmd.cor_a = 1'b1;
				state_d   = ST_CORAW;
			end
			ST_CORAW: begin
				if (sts.cor_done)
					state_d = ST_MULM;
			end
			ST_MULM: begin
				cmd.mulm = 1'b1;
				state_d  = ST_MULXY;
			end
			ST_MULXY: begin
				cmd.mulxy = 1'b1;
				state_d   = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: rtl/core/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning odometry for a two-wheel robot base.
// ----------------------------------------------------------------------------
// in_ch carries one sample per item: the absolute left and right encoder
// counts and a microsecond timestamp. out_ch returns one item per sample:
// pose x and y (Q16.16 m), heading (Q3.28 rad) and both wheel rates
// (Q16.16 rad/s). The cfg port writes ticks per revolution, wheel radius
// and axle length; the user must write them only while the block is idle,
// as the block itself does not enforce this. A sample runs from accept to
// result through four setup steps, four parallel bit-serial dividers, then
// two passes of one shared cordic of 24 iterations, plus a handful of
// multiply steps. The next sample is accepted the cycle after the result is
// loaded, so no new sample is taken until the current one is through.
// Reset clears the pose, the previous sample and the output valid flag, and
// loads the default configuration. A stalled receiver holds the result in
// the output register; a following sample still runs and then waits at its
// final step until the register frees up.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
	input  logic        clk,
	input  logic        arst_n,
	ddo_in_if.sink      in_ch,
	ddo_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_wdata
);

	ddo_pkg::cmd_t cmd;
	ddo_pkg::sts_t sts;

	ddo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	ddo_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_left(in_ch.left_count), .in_right(in_ch.right_count), .in_time(in_ch.time_us),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_x(out_ch.pos_x), .out_y(out_ch.pos_y), .out_heading(out_ch.heading),
		.out_lrate(out_ch.left_rate), .out_rrate(out_ch.right_rate)
	);

endmodule
